@@ design/keypad_press_event_scanner_macros.svh @@
// assertion macros used by the checker of the keypad scanner
`ifndef KEYPAD_PRESS_EVENT_SCANNER_MACROS_SVH
`define KEYPAD_PRESS_EVENT_SCANNER_MACROS_SVH

// same-cycle implication, quiet during reset
`define KPES_ASSERT_IMPL(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define KPES_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

// next-cycle implication, also checked across reset
`define KPES_ASSERT_NEXT_ALWAYS(lbl, clk, pre, post, msg) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ design/kpes_pkg.sv @@
package kpes_pkg;

  localparam int KPES_BUTTONS = 32;
  localparam int MASK_W       = 32;
  localparam int IDX_W        = 5;
  localparam int ACT_W        = 2;
  localparam int CNT_W        = 8;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 8;

  localparam logic [ACT_W-1:0] ACT_DOWN = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LONG = 2'd1;
  localparam logic [ACT_W-1:0] ACT_UP   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PRESS_TH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TH  = 1'd1;

  localparam logic [CNT_W-1:0] PRESS_TH_RST = 8'd1;
  localparam logic [CNT_W-1:0] LONG_TH_RST  = 8'd20;
  localparam logic [CNT_W-1:0] COUNT_MAX    = 8'hFF;

  typedef struct packed {
    logic             event_valid;
    logic [IDX_W-1:0] button_index;
    logic [ACT_W-1:0] action;
  } kpes_res_t;

endpackage

@@ design/kpes_if.sv @@
interface kpes_in_if import kpes_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] pressed_mask;

  modport source (output valid, output pressed_mask, input ready);
  modport sink (input valid, input pressed_mask, output ready);
endinterface

interface kpes_out_if import kpes_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             event_valid;
  logic [IDX_W-1:0] button_index;
  logic [ACT_W-1:0] action;

  modport source (output valid, output event_valid, output button_index, output action,
                  input ready);
  modport sink (input valid, input event_valid, input button_index, input action,
                output ready);
endinterface

@@ design/kpes_walker.sv @@
module kpes_walker import kpes_pkg::*; #(
  parameter int BUTTONS = KPES_BUTTONS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MASK_W-1:0] mask,
  input  logic [CNT_W-1:0]  press_th,
  input  logic [CNT_W-1:0]  long_th,
  input  logic              take,
  output logic              busy,
  output logic              res_valid,
  output kpes_res_t         res
);

  localparam int IW = $clog2(BUTTONS);

  logic [IW-1:0]      cnt;
  logic [IW+IDX_W-1:0] cnt_ext;
  logic               stopped;
  logic [MASK_W-1:0]  mask_sr;
  logic [BUTTONS-1:0] ring;
  logic [CNT_W-1:0]   hold;
  logic [CNT_W-1:0]   hold_next;
  logic [CNT_W-1:0]   hold_inc;
  logic               kd_new;
  logic               hit;
  logic               stop_now;
  logic [ACT_W-1:0]   act;
  logic               last;

  assign cnt_ext  = {{IDX_W{1'b0}}, cnt};
  assign last     = (cnt == IW'(BUTTONS - 1));
  assign hold_inc = (hold == COUNT_MAX) ? hold : hold + CNT_W'(1);

  // one button per cycle: mask bit and key state both sit at bit 0
  always_comb begin
    kd_new    = ring[0];
    hold_next = hold;
    hit       = 1'b0;
    stop_now  = 1'b0;
    act       = ACT_DOWN;
    if (!stopped) begin
      if (mask_sr[0]) begin
        hold_next = hold_inc;
        if (hold_inc >= press_th) begin
          stop_now = 1'b1;
          if (!ring[0]) begin
            kd_new = 1'b1;
            hit    = 1'b1;
            act    = ACT_DOWN;
          end else if (hold_inc >= long_th) begin
            hold_next = long_th;
            hit       = 1'b1;
            act       = ACT_LONG;
          end
        end
      end else if (ring[0]) begin
        kd_new    = 1'b0;
        hold_next = '0;
        hit       = 1'b1;
        act       = ACT_UP;
        stop_now  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      res_valid <= 1'b0;
      stopped   <= 1'b0;
      cnt       <= '0;
      hold      <= '0;
      ring      <= '0;
    end else begin
      if (take) begin
        res_valid <= 1'b0;
      end
      if (start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        stopped <= 1'b0;
      end else if (busy) begin
        // the ring turns a full lap every scan, so it stays aligned
        ring <= {kd_new, ring[BUTTONS-1:1]};
        hold <= hold_next;
        cnt  <= cnt + IW'(1);
        if (stop_now) begin
          stopped <= 1'b1;
        end
        if (last) begin
          busy      <= 1'b0;
          res_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mask_sr <= mask;
      res     <= '0;
    end else if (busy) begin
      mask_sr <= {1'b0, mask_sr[MASK_W-1:1]};
      if (hit) begin
        res.event_valid  <= 1'b1;
        res.button_index <= cnt_ext[IDX_W-1:0];
        res.action       <= act;
      end
    end
  end

endmodule

@@ design/keypad_press_event_scanner.sv @@
// keypad press event scanner
// in_ch carries one scan per item: pressed_mask, bit row + 8 * line per button.
// out_ch carries one result per scan: event_valid, button_index and action
// (down, long press, released); all three are zero when the scan has no event.
// cfg_we / cfg_index / cfg_data write press_threshold (index 0) and
// long_threshold (index 1); write only while no scan is in flight.
// a scan walks the buttons one per cycle through a mask shift register and a
// ring of key-down bits; the walker then hands its result to the output
// register, which drives out_ch.valid. A new scan is taken only once the
// walker has handed its result on to the output register.
// the output register parts the two sides: while a result waits for
// out_ch.ready the next scan may already be accepted and walked; it is then
// held in the walker until the output register frees up.
// reset (rst, synchronous) marks every key up, clears the hold counter,
// empties both stages and sets the thresholds to 1 and 20.
module keypad_press_event_scanner import kpes_pkg::*; #(
  parameter int BUTTONS = KPES_BUTTONS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  kpes_in_if.sink               in_ch,
  kpes_out_if.source            out_ch
);

  logic [CNT_W-1:0] press_th;
  logic [CNT_W-1:0] long_th;
  logic             busy;
  logic             res_valid;
  kpes_res_t        res;
  logic             start;
  logic             take;
  logic             out_valid;
  kpes_res_t        out_res;

  assign in_ch.ready = !busy && !res_valid;
  assign start       = in_ch.valid && in_ch.ready;
  assign take        = res_valid && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      press_th <= PRESS_TH_RST;
      long_th  <= LONG_TH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PRESS_TH: press_th <= cfg_data;
        REG_LONG_TH:  long_th  <= cfg_data;
        default: ;
      endcase
    end
  end

  kpes_walker #(
    .BUTTONS (BUTTONS)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .mask      (in_ch.pressed_mask),
    .press_th  (press_th),
    .long_th   (long_th),
    .take      (take),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res <= res;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.event_valid  = out_res.event_valid;
  assign out_ch.button_index = out_res.button_index;
  assign out_ch.action       = out_res.action;

endmodule

@@ design/kpes_checker.sv @@
`include "keypad_press_event_scanner_macros.svh"

module kpes_checker import kpes_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             event_valid,
  input logic [IDX_W-1:0] button_index,
  input logic [ACT_W-1:0] action
);

  // a stalled result holds its payload
  `KPES_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(event_valid) && $stable(button_index) && $stable(action), "stalled result changed")

  // a scan keeps the walker busy, so the block cannot take two in a row
  `KPES_ASSERT_NEXT(a_no_back_to_back, clk, rst, in_valid && in_ready, !in_ready, "scan accepted while previous one still walking")

  // a result without an event carries zero index and action
  `KPES_ASSERT_IMPL(a_quiet_zero, clk, rst, out_valid && !event_valid, button_index == '0 && action == ACT_DOWN, "empty result has non-zero fields")

  // reset empties the output stage
  `KPES_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid, "result shown straight after reset")

endmodule

bind keypad_press_event_scanner kpes_checker u_kpes_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .event_valid  (out_ch.event_valid),
  .button_index (out_ch.button_index),
  .action       (out_ch.action)
);

@@ tb/sv/tb_keypad_press_event_scanner.sv @@
`timescale 1ns / 1ps

module tb_keypad_press_event_scanner;
  import kpes_pkg::*;

  localparam int          HALF_PERIOD  = 4;
  localparam int          RESET_CYCLES = 7;
  localparam int          SETTLE_GAP   = KPES_BUTTONS + 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned CHUNK_SCANS  = 133;

  // thresholds are rewritten before items 11, 16 and 21
  localparam logic [MASK_W-1:0] DIRECTED_SCANS [25] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0003, 32'h0000_0002, 32'h8000_0000,
    32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000,
    32'h0000_0000,
    32'h0000_000F, 32'h0000_0004, 32'h0000_0004, 32'h0000_0004, 32'h0000_0000,
    32'h0000_000F, 32'h0000_0008, 32'h0000_0008, 32'h0000_0001, 32'h0000_0000,
    32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000
  };

  class key_event_tracker;
    bit               key_down [KPES_BUTTONS];
    logic [CNT_W-1:0] hold_count;
    logic [CNT_W-1:0] press_th;
    logic [CNT_W-1:0] long_th;
    kpes_res_t        expected_events [$];
    int unsigned      fails;

    function new();
      foreach (key_down[b]) key_down[b] = 1'b0;
      hold_count = '0;
      press_th   = PRESS_TH_RST;
      long_th    = LONG_TH_RST;
      fails      = 0;
    endfunction

    function void set_threshold(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_PRESS_TH: press_th = val;
        REG_LONG_TH:  long_th = val;
        default: ;
      endcase
    endfunction

    // walk the buttons from 0 upward, stopping at the first one that speaks
    function void note_scan(logic [MASK_W-1:0] mask);
      kpes_res_t ev;
      ev = '0;
      for (int b = 0; b < KPES_BUTTONS; b++) begin
        if (b < MASK_W && mask[b]) begin
          if (hold_count != COUNT_MAX) hold_count = hold_count + 1'b1;
          if (hold_count < press_th) continue;
          if (!key_down[b]) begin
            key_down[b]     = 1'b1;
            ev.event_valid  = 1'b1;
            ev.button_index = IDX_W'(b);
            ev.action       = ACT_DOWN;
          end else if (hold_count >= long_th) begin
            hold_count      = long_th;
            ev.event_valid  = 1'b1;
            ev.button_index = IDX_W'(b);
            ev.action       = ACT_LONG;
          end
          // a held key below the long threshold still ends the walk
          break;
        end else if (key_down[b]) begin
          key_down[b]     = 1'b0;
          hold_count      = '0;
          ev.event_valid  = 1'b1;
          ev.button_index = IDX_W'(b);
          ev.action       = ACT_UP;
          break;
        end
      end
      expected_events.push_back(ev);
    endfunction

    function void check_result(kpes_res_t got);
      kpes_res_t want;
      if (expected_events.size() == 0) begin
        $error("unexpected item: event_valid %0d button_index %0d action %0d",
               got.event_valid, got.button_index, got.action);
        fails++;
        return;
      end
      want = expected_events.pop_front();
      if (got.event_valid !== want.event_valid) begin
        $error("event_valid: expected %0d, actual %0d", want.event_valid, got.event_valid);
        fails++;
      end
      if (got.button_index !== want.button_index) begin
        $error("button_index: expected %0d, actual %0d", want.button_index, got.button_index);
        fails++;
      end
      if (got.action !== want.action) begin
        $error("action: expected %0d, actual %0d", want.action, got.action);
        fails++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  kpes_in_if  in_ch ();
  kpes_out_if out_ch ();

  keypad_press_event_scanner u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  key_event_tracker tracker = new();
  int unsigned      src_idle;
  int unsigned      snk_idle;
  int unsigned      scans_sent;

  always begin
    clk = 1'b0;
    #HALF_PERIOD;
    clk = 1'b1;
    #HALF_PERIOD;
  end

  task automatic send_scan(logic [MASK_W-1:0] mask);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid        <= 1'b0;
      in_ch.pressed_mask <= $urandom();
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.pressed_mask <= mask;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_scan(mask);
    scans_sent++;
  endtask

  // drain every pending event before touching the thresholds
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tracker.expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic write_thresholds(logic [CFG_DATA_W-1:0] press_th, logic [CFG_DATA_W-1:0] long_th);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PRESS_TH;
    cfg_data  <= press_th;
    @(posedge clk);
    tracker.set_threshold(REG_PRESS_TH, press_th);
    cfg_index <= REG_LONG_TH;
    cfg_data  <= long_th;
    @(posedge clk);
    tracker.set_threshold(REG_LONG_TH, long_th);
    cfg_we <= 1'b0;
  endtask

  // a key or chord held for a while and then let go, now and then with stray closures
  task automatic play_press();
    logic [MASK_W-1:0] keys;
    int                hold_len;
    case ($urandom_range(7))
      0: keys = '1;
      1: keys = $urandom();
      2: keys = (32'h1 << $urandom_range(31)) | (32'h1 << $urandom_range(31));
      default: keys = 32'h1 << $urandom_range(31);
    endcase
    hold_len = ($urandom_range(5) == 0) ? $urandom_range(45, 13) : $urandom_range(12, 1);
    repeat (hold_len) send_scan(($urandom_range(9) == 0) ? (keys | $urandom()) : keys);
    send_scan(($urandom_range(2) == 0) ? ($urandom() & ~keys) : '0);
    repeat ($urandom_range(2)) send_scan('0);
  endtask

  initial begin
    kpes_res_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        got.event_valid  = out_ch.event_valid;
        got.button_index = out_ch.button_index;
        got.action       = out_ch.action;
        tracker.check_result(got);
      end
      out_ch.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned target;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_PRESS_TH;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.pressed_mask <= '0;
    src_idle   = 38;
    snk_idle   = 59;
    scans_sent = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset thresholds first, then a long threshold above, below and at zero
    foreach (DIRECTED_SCANS[i]) begin
      case (i)
        11: begin settle(); write_thresholds(8'd3, 8'd5); end
        16: begin settle(); write_thresholds(8'd4, 8'd2); end
        21: begin settle(); write_thresholds(8'd0, 8'd0); end
        default: ;
      endcase
      send_scan(DIRECTED_SCANS[i]);
    end

    target = scans_sent;
    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 38 : (ph == 1) ? 59 : 0;
      snk_idle = (ph == 0) ? 59 : (ph == 1) ? 38 : 0;
      for (int s = 0; s < 2; s++) begin
        settle();
        case (ph * 2 + s)
          0: write_thresholds(8'd1, 8'd20);
          1: write_thresholds(8'd255, 8'd255);
          2: write_thresholds(8'd0, 8'd0);
          3: write_thresholds(8'd2, 8'd7);
          4: write_thresholds(8'd9, 8'd3);
          default: write_thresholds(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
        endcase
        target += CHUNK_SCANS;
        while (scans_sent < target) play_press();
      end
    end

    settle();
    if (tracker.fails == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ keypad_press_event_scanner.f @@
+incdir+design
design/kpes_pkg.sv
design/kpes_if.sv
design/kpes_walker.sv
design/keypad_press_event_scanner.sv
design/kpes_checker.sv
tb/sv/tb_keypad_press_event_scanner.sv
